>>> hw/rtl/wfos_pkg.sv
// Shared types, constants and tables for the waypoint follower sequencer.
package wfos_pkg;

    localparam int MAX_WAYPOINTS_DEF = 64;
    localparam int CORDIC_STEPS_DEF  = 14;

    localparam int POS_W   = 24;
    localparam int HEAD_W  = 16;
    localparam int ALT_W   = 24;
    localparam int RAD_W   = 23;
    localparam int WARM_W  = 17;
    localparam int TICK_W  = 16;
    localparam int CODE_W  = 2;
    localparam int OP_W    = 3;
    localparam int DIFF_W  = POS_W + 1;
    localparam int SQ_W    = 2 * DIFF_W;
    localparam int CW      = 28;
    localparam int ZW      = 17;
    localparam int AIDX_W  = 5;
    localparam int NORM_BITS = 24;
    localparam int APB_AW  = 5;
    localparam int APB_DW  = 32;

    localparam int ANGLE_PI    = 25736;
    localparam int NEAR_SQ_MAX = 2621;
    localparam int WARM_MAX    = 100000;

    localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
    localparam logic [OP_W-1:0] OP_POS    = 3'd1;
    localparam logic [OP_W-1:0] OP_STATUS = 3'd2;
    localparam logic [OP_W-1:0] OP_LOAD   = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

    localparam logic [CODE_W-1:0] CMD_NONE     = 2'd0;
    localparam logic [CODE_W-1:0] CMD_OFFBOARD = 2'd1;
    localparam logic [CODE_W-1:0] CMD_ARM      = 2'd2;

    typedef enum logic [2:0] {
        REG_ALT      = 3'd0,
        REG_RADIUS   = 3'd1,
        REG_WARMUP   = 3'd2,
        REG_RESEND   = 3'd3,
        REG_HOLD_X   = 3'd4,
        REG_HOLD_Y   = 3'd5,
        REG_AUTO_OFB = 3'd6,
        REG_AUTO_ARM = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic signed [ALT_W-1:0] cruise_altitude;
        logic [RAD_W-1:0]        accept_radius;
        logic [WARM_W-1:0]       warmup_ticks;
        logic [TICK_W-1:0]       resend_ticks;
        logic signed [POS_W-1:0] hold_x;
        logic signed [POS_W-1:0] hold_y;
        logic                    auto_offboard;
        logic                    auto_arm;
    } t_cfg;

    typedef enum logic [4:0] {
        S_IDLE, S_R2, S_W_CHK, S_W_RD, S_W_DIFF, S_W_SQX, S_W_SQY, S_W_CMP,
        S_T_RD, S_T_SEL, S_Y_SQX, S_Y_SQY, S_Y_CHK, S_C_INIT, S_C_NORM,
        S_C_ITER, S_FIN
    } t_state;

    typedef enum logic [3:0] {
        DP_NOP, DP_ACCEPT, DP_R2, DP_RD, DP_DIFF, DP_SQX, DP_SQY, DP_ADV,
        DP_TSEL, DP_CINIT, DP_CNORM, DP_CITER, DP_EMIT
    } t_dp_op;

    typedef struct packed {
        logic walk_more;
        logic far_accept;
        logic far_near;
        logic pos_known;
        logic norm_more;
        logic iter_last;
        logic out_free;
    } t_dp_status;

    function automatic logic signed [ZW-1:0] atan_entry(input logic [AIDX_W-1:0] idx);
        logic signed [ZW-1:0] v;
        case (idx)
            5'd0:    v = 17'sd6434;
            5'd1:    v = 17'sd3798;
            5'd2:    v = 17'sd2007;
            5'd3:    v = 17'sd1019;
            5'd4:    v = 17'sd511;
            5'd5:    v = 17'sd256;
            5'd6:    v = 17'sd128;
            5'd7:    v = 17'sd64;
            5'd8:    v = 17'sd32;
            5'd9:    v = 17'sd16;
            5'd10:   v = 17'sd8;
            5'd11:   v = 17'sd4;
            5'd12:   v = 17'sd2;
            5'd13:   v = 17'sd1;
            default: v = 17'sd0;
        endcase
        return v;
    endfunction

endpackage

>>> hw/rtl/wfos_if.sv
// Valid/ready channel interfaces for input items and setpoint results.
interface wfos_in_if;
    logic                             valid;
    logic                             ready;
    logic [wfos_pkg::OP_W-1:0]        opcode;
    logic signed [wfos_pkg::POS_W-1:0] in_x;
    logic signed [wfos_pkg::POS_W-1:0] in_y;
    logic signed [wfos_pkg::HEAD_W-1:0] in_heading;
    logic                             xy_ok;
    logic                             heading_ok;
    logic                             armed_flag;
    logic                             offboard_flag;
    logic                             last_point;

    modport source (output valid, opcode, in_x, in_y, in_heading, xy_ok, heading_ok,
                    armed_flag, offboard_flag, last_point, input ready);
    modport sink (input valid, opcode, in_x, in_y, in_heading, xy_ok, heading_ok,
                  armed_flag, offboard_flag, last_point, output ready);
endinterface

interface wfos_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [wfos_pkg::POS_W-1:0]  setpoint_x;
    logic signed [wfos_pkg::POS_W-1:0]  setpoint_y;
    logic signed [wfos_pkg::ALT_W-1:0]  setpoint_z;
    logic signed [wfos_pkg::HEAD_W-1:0] setpoint_yaw;
    logic [wfos_pkg::CODE_W-1:0]        command_code;

    modport source (output valid, setpoint_x, setpoint_y, setpoint_z, setpoint_yaw,
                    command_code, input ready);
    modport sink (input valid, setpoint_x, setpoint_y, setpoint_z, setpoint_yaw,
                  command_code, output ready);
endinterface

>>> hw/rtl/wfos_ctrl.sv
// Controller state machine: accepts input items and sequences the datapath through each tick.
module wfos_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic [wfos_pkg::OP_W-1:0] i_opcode,
    output logic                      o_in_ready,
    input  wfos_pkg::t_dp_status      i_status,
    output wfos_pkg::t_dp_op          o_dp_op
);

    wfos_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wfos_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_dp_op    = wfos_pkg::DP_NOP;
        o_in_ready = 1'b0;
        case (r_state)
            wfos_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_dp_op = wfos_pkg::DP_ACCEPT;
                    if (i_opcode == wfos_pkg::OP_TICK) begin
                        n_state = wfos_pkg::S_R2;
                    end
                end
            end
            wfos_pkg::S_R2: begin
                o_dp_op = wfos_pkg::DP_R2;
                n_state = wfos_pkg::S_W_CHK;
            end
            wfos_pkg::S_W_CHK: begin
                n_state = i_status.walk_more ? wfos_pkg::S_W_RD : wfos_pkg::S_T_RD;
            end
            wfos_pkg::S_W_RD: begin
                o_dp_op = wfos_pkg::DP_RD;
                n_state = wfos_pkg::S_W_DIFF;
            end
            wfos_pkg::S_W_DIFF: begin
                o_dp_op = wfos_pkg::DP_DIFF;
                n_state = wfos_pkg::S_W_SQX;
            end
            wfos_pkg::S_W_SQX: begin
                o_dp_op = wfos_pkg::DP_SQX;
                n_state = wfos_pkg::S_W_SQY;
            end
            wfos_pkg::S_W_SQY: begin
                o_dp_op = wfos_pkg::DP_SQY;
                n_state = wfos_pkg::S_W_CMP;
            end
            wfos_pkg::S_W_CMP: begin
                if (i_status.far_accept) begin
                    n_state = wfos_pkg::S_T_RD;
                end else begin
                    o_dp_op = wfos_pkg::DP_ADV;
                    n_state = wfos_pkg::S_W_CHK;
                end
            end
            wfos_pkg::S_T_RD: begin
                o_dp_op = wfos_pkg::DP_RD;
                n_state = wfos_pkg::S_T_SEL;
            end
            wfos_pkg::S_T_SEL: begin
                o_dp_op = wfos_pkg::DP_TSEL;
                n_state = wfos_pkg::S_Y_SQX;
            end
            wfos_pkg::S_Y_SQX: begin
                o_dp_op = wfos_pkg::DP_SQX;
                n_state = wfos_pkg::S_Y_SQY;
            end
            wfos_pkg::S_Y_SQY: begin
                o_dp_op = wfos_pkg::DP_SQY;
                n_state = wfos_pkg::S_Y_CHK;
            end
            wfos_pkg::S_Y_CHK: begin
                if (i_status.pos_known && i_status.far_near) begin
                    n_state = wfos_pkg::S_C_INIT;
                end else begin
                    n_state = wfos_pkg::S_FIN;
                end
            end
            wfos_pkg::S_C_INIT: begin
                o_dp_op = wfos_pkg::DP_CINIT;
                n_state = wfos_pkg::S_C_NORM;
            end
            wfos_pkg::S_C_NORM: begin
                o_dp_op = wfos_pkg::DP_CNORM;
                if (!i_status.norm_more) begin
                    n_state = wfos_pkg::S_C_ITER;
                end
            end
            wfos_pkg::S_C_ITER: begin
                o_dp_op = wfos_pkg::DP_CITER;
                if (i_status.iter_last) begin
                    n_state = wfos_pkg::S_FIN;
                end
            end
            wfos_pkg::S_FIN: begin
                if (i_status.out_free) begin
                    o_dp_op = wfos_pkg::DP_EMIT;
                    n_state = wfos_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = wfos_pkg::S_IDLE;
            end
        endcase
    end

endmodule

>>> hw/rtl/wfos_dp.sv
// Datapath: path store, vehicle state, distance unit, CORDIC and output register.
module wfos_dp #(
    parameter int MAX_WAYPOINTS = wfos_pkg::MAX_WAYPOINTS_DEF,
    parameter int CORDIC_STEPS  = wfos_pkg::CORDIC_STEPS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  wfos_pkg::t_dp_op                   i_dp_op,
    input  wfos_pkg::t_cfg                     i_cfg,
    input  logic [wfos_pkg::OP_W-1:0]          i_opcode,
    input  logic signed [wfos_pkg::POS_W-1:0]  i_in_x,
    input  logic signed [wfos_pkg::POS_W-1:0]  i_in_y,
    input  logic signed [wfos_pkg::HEAD_W-1:0] i_in_heading,
    input  logic                               i_xy_ok,
    input  logic                               i_heading_ok,
    input  logic                               i_armed_flag,
    input  logic                               i_offboard_flag,
    input  logic                               i_last_point,
    output wfos_pkg::t_dp_status               o_status,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic signed [wfos_pkg::POS_W-1:0]  o_setpoint_x,
    output logic signed [wfos_pkg::POS_W-1:0]  o_setpoint_y,
    output logic signed [wfos_pkg::ALT_W-1:0]  o_setpoint_z,
    output logic signed [wfos_pkg::HEAD_W-1:0] o_setpoint_yaw,
    output logic [wfos_pkg::CODE_W-1:0]        o_command_code
);

    localparam int IW  = $clog2(MAX_WAYPOINTS);
    localparam int PCW = $clog2(MAX_WAYPOINTS + 1);
    localparam int CIW = $clog2(CORDIC_STEPS);
    localparam int PW  = wfos_pkg::POS_W;
    localparam int DW  = wfos_pkg::DIFF_W;
    localparam int SW  = wfos_pkg::SQ_W;
    localparam int CW  = wfos_pkg::CW;
    localparam int ZW  = wfos_pkg::ZW;
    localparam int TW  = wfos_pkg::TICK_W;
    localparam int WW  = wfos_pkg::WARM_W;
    localparam int RW2 = 2 * wfos_pkg::RAD_W;
    localparam logic [PCW-1:0] MAX_CNT = PCW'(MAX_WAYPOINTS);
    localparam logic [CW-1:0] NORM_LIM = CW'(32'd1 << wfos_pkg::NORM_BITS);
    localparam logic signed [ZW-1:0] Z_PI = ZW'(wfos_pkg::ANGLE_PI);
    localparam logic [SW-1:0] NEAR_SQ = SW'(wfos_pkg::NEAR_SQ_MAX);
    localparam logic [TW-1:0] TICK_SAT = '1;
    localparam logic [WW-1:0] WARM_MAX = WW'(wfos_pkg::WARM_MAX);

    // waypoint store, x in the upper half
    logic [2*PW-1:0] r_mem [MAX_WAYPOINTS];
    logic [2*PW-1:0] r_rdata;

    logic [PCW-1:0]          r_count;
    logic [IW-1:0]           r_ti;
    logic                    r_path_ready;
    logic signed [PW-1:0]    r_pos_x, r_pos_y;
    logic signed [wfos_pkg::HEAD_W-1:0] r_heading;
    logic                    r_pos_known;
    logic                    r_st_valid, r_st_armed, r_st_offboard;
    logic [WW-1:0]           r_warm;
    logic [TW-1:0]           r_ticks;

    logic [RW2-1:0]          r_r2;
    logic signed [DW-1:0]    r_dx, r_dy;
    logic [SW-1:0]           r_acc;
    logic signed [PW-1:0]    r_tx, r_ty;
    logic signed [CW-1:0]    r_cx, r_cy;
    logic signed [ZW-1:0]    r_cz;
    logic [CIW-1:0]          r_ci;
    logic                    r_use_cordic;

    logic                    r_out_valid;
    logic signed [PW-1:0]    r_sp_x, r_sp_y;
    logic signed [wfos_pkg::ALT_W-1:0]  r_sp_z;
    logic signed [wfos_pkg::HEAD_W-1:0] r_sp_yaw;
    logic [wfos_pkg::CODE_W-1:0]        r_sp_code;

    logic                    accept;
    logic [PCW-1:0]          load_base;
    logic                    mem_we;
    logic signed [PW-1:0]    rd_x, rd_y;
    logic [DW-1:0]           ax, ay, mul_a;
    logic [SW-1:0]           mul_p;
    logic signed [PW-1:0]    sel_x, sel_y;
    logic [CW-1:0]           cm_x, cm_y, cm;
    logic                    norm_more;
    logic signed [CW-1:0]    xs, ys;
    logic signed [ZW-1:0]    z_clamp;
    logic [TW-1:0]           ticks_inc;
    logic [WW-1:0]           warm_eff;
    logic [wfos_pkg::CODE_W-1:0] code;
    logic [TW-1:0]           ticks_next;
    logic [WW-1:0]           warm_next;
    logic                    out_free;

    assign accept    = (i_dp_op == wfos_pkg::DP_ACCEPT);
    assign load_base = r_path_ready ? '0 : r_count;
    assign mem_we    = accept && (i_opcode == wfos_pkg::OP_LOAD) && (load_base < MAX_CNT);
    assign rd_x      = r_rdata[2*PW-1:PW];
    assign rd_y      = r_rdata[PW-1:0];

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[load_base[IW-1:0]] <= {i_in_x, i_in_y};
        end
        if (i_dp_op == wfos_pkg::DP_RD) begin
            r_rdata <= r_mem[r_ti];
        end
    end

    // shared squarer: one 25x25 multiply per cycle
    assign ax    = r_dx[DW-1] ? DW'(-r_dx) : DW'(r_dx);
    assign ay    = r_dy[DW-1] ? DW'(-r_dy) : DW'(r_dy);
    always_comb begin
        case (i_dp_op)
            wfos_pkg::DP_R2:  mul_a = DW'(i_cfg.accept_radius);
            wfos_pkg::DP_SQY: mul_a = ay;
            default:          mul_a = ax;
        endcase
    end
    assign mul_p = mul_a * mul_a;

    // target: waypoint, else position, else hold point
    always_comb begin
        if (r_path_ready && (PCW'(r_ti) < r_count)) begin
            sel_x = rd_x;
            sel_y = rd_y;
        end else if (r_pos_known) begin
            sel_x = r_pos_x;
            sel_y = r_pos_y;
        end else begin
            sel_x = i_cfg.hold_x;
            sel_y = i_cfg.hold_y;
        end
    end

    assign cm_x      = CW'(r_cx);
    assign cm_y      = r_cy[CW-1] ? CW'(-r_cy) : CW'(r_cy);
    assign cm        = (cm_x > cm_y) ? cm_x : cm_y;
    assign norm_more = (cm != '0) && (cm < NORM_LIM);
    assign xs        = r_cx >>> r_ci;
    assign ys        = r_cy >>> r_ci;

    always_comb begin
        if (r_cz > Z_PI) begin
            z_clamp = Z_PI;
        end else if (r_cz < -Z_PI) begin
            z_clamp = -Z_PI;
        end else begin
            z_clamp = r_cz;
        end
    end

    // command sequencing
    always_comb begin
        ticks_inc = (r_ticks != TICK_SAT) ? r_ticks + TW'(1) : r_ticks;
        if (i_cfg.warmup_ticks == '0) begin
            warm_eff = WW'(1);
        end else if (i_cfg.warmup_ticks > WARM_MAX) begin
            warm_eff = WARM_MAX;
        end else begin
            warm_eff = i_cfg.warmup_ticks;
        end
        code       = wfos_pkg::CMD_NONE;
        ticks_next = ticks_inc;
        warm_next  = r_warm;
        if (r_warm < warm_eff) begin
            warm_next = r_warm + WW'(1);
        end else if (ticks_inc >= i_cfg.resend_ticks) begin
            if (i_cfg.auto_offboard && !(r_st_valid && r_st_offboard)) begin
                code       = wfos_pkg::CMD_OFFBOARD;
                ticks_next = '0;
            end else if (i_cfg.auto_arm && !(r_st_valid && r_st_armed)) begin
                code       = wfos_pkg::CMD_ARM;
                ticks_next = '0;
            end
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count       <= '0;
            r_ti          <= '0;
            r_path_ready  <= 1'b0;
            r_pos_x       <= '0;
            r_pos_y       <= '0;
            r_heading     <= '0;
            r_pos_known   <= 1'b0;
            r_st_valid    <= 1'b0;
            r_st_armed    <= 1'b0;
            r_st_offboard <= 1'b0;
            r_warm        <= '0;
            r_ticks       <= TICK_SAT;
            r_use_cordic  <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            case (i_dp_op)
                wfos_pkg::DP_ACCEPT: begin
                    case (i_opcode)
                        wfos_pkg::OP_POS: begin
                            if (i_xy_ok) begin
                                r_pos_x     <= i_in_x;
                                r_pos_y     <= i_in_y;
                                r_pos_known <= 1'b1;
                                if (i_heading_ok) begin
                                    r_heading <= i_in_heading;
                                end
                            end
                        end
                        wfos_pkg::OP_STATUS: begin
                            r_st_valid    <= 1'b1;
                            r_st_armed    <= i_armed_flag;
                            r_st_offboard <= i_offboard_flag;
                        end
                        wfos_pkg::OP_LOAD: begin
                            r_count <= (load_base < MAX_CNT) ? load_base + PCW'(1) : load_base;
                            if (r_path_ready || i_last_point) begin
                                r_ti <= '0;
                            end
                            r_path_ready <= i_last_point;
                        end
                        wfos_pkg::OP_CLEAR: begin
                            r_path_ready <= 1'b0;
                            r_count      <= '0;
                            r_ti         <= '0;
                        end
                        default: ;
                    endcase
                end
                wfos_pkg::DP_ADV: r_ti <= r_ti + IW'(1);
                wfos_pkg::DP_TSEL: r_use_cordic <= 1'b0;
                wfos_pkg::DP_CINIT: r_use_cordic <= 1'b1;
                wfos_pkg::DP_EMIT: begin
                    r_ticks     <= ticks_next;
                    r_warm      <= warm_next;
                    r_out_valid <= 1'b1;
                end
                default: ;
            endcase
            if (i_dp_op != wfos_pkg::DP_EMIT && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // arithmetic payload registers
    always_ff @(posedge i_clk) begin
        case (i_dp_op)
            wfos_pkg::DP_R2:  r_r2 <= mul_p[RW2-1:0];
            wfos_pkg::DP_DIFF: begin
                r_dx <= DW'(r_pos_x) - DW'(rd_x);
                r_dy <= DW'(r_pos_y) - DW'(rd_y);
            end
            wfos_pkg::DP_SQX: r_acc <= mul_p;
            wfos_pkg::DP_SQY: r_acc <= r_acc + mul_p;
            wfos_pkg::DP_TSEL: begin
                r_tx <= sel_x;
                r_ty <= sel_y;
                r_dx <= DW'(sel_x) - DW'(r_pos_x);
                r_dy <= DW'(sel_y) - DW'(r_pos_y);
            end
            wfos_pkg::DP_CINIT: begin
                r_ci <= '0;
                if (r_dx[DW-1]) begin
                    r_cx <= -CW'(r_dx);
                    r_cy <= -CW'(r_dy);
                    r_cz <= r_dy[DW-1] ? -Z_PI : Z_PI;
                end else begin
                    r_cx <= CW'(r_dx);
                    r_cy <= CW'(r_dy);
                    r_cz <= '0;
                end
            end
            wfos_pkg::DP_CNORM: begin
                if (norm_more) begin
                    r_cx <= r_cx <<< 1;
                    r_cy <= r_cy <<< 1;
                end
            end
            wfos_pkg::DP_CITER: begin
                r_ci <= r_ci + CIW'(1);
                if (!r_cy[CW-1]) begin
                    r_cx <= r_cx + ys;
                    r_cy <= r_cy - xs;
                    r_cz <= r_cz + wfos_pkg::atan_entry(wfos_pkg::AIDX_W'(r_ci));
                end else begin
                    r_cx <= r_cx - ys;
                    r_cy <= r_cy + xs;
                    r_cz <= r_cz - wfos_pkg::atan_entry(wfos_pkg::AIDX_W'(r_ci));
                end
            end
            wfos_pkg::DP_EMIT: begin
                r_sp_x    <= r_tx;
                r_sp_y    <= r_ty;
                r_sp_z    <= i_cfg.cruise_altitude[wfos_pkg::ALT_W-1] ?
                             i_cfg.cruise_altitude : -i_cfg.cruise_altitude;
                r_sp_yaw  <= r_use_cordic ? wfos_pkg::HEAD_W'(z_clamp) : r_heading;
                r_sp_code <= code;
            end
            default: ;
        endcase
    end

    assign o_status.walk_more  = r_path_ready && r_pos_known &&
                                 ((PCW'(r_ti) + PCW'(1)) < r_count);
    assign o_status.far_accept = r_acc > SW'(r_r2);
    assign o_status.far_near   = r_acc > NEAR_SQ;
    assign o_status.pos_known  = r_pos_known;
    assign o_status.norm_more  = norm_more;
    assign o_status.iter_last  = (r_ci == CIW'(CORDIC_STEPS - 1));
    assign o_status.out_free   = out_free;

    assign o_out_valid    = r_out_valid;
    assign o_setpoint_x   = r_sp_x;
    assign o_setpoint_y   = r_sp_y;
    assign o_setpoint_z   = r_sp_z;
    assign o_setpoint_yaw = r_sp_yaw;
    assign o_command_code = r_sp_code;

endmodule

>>> hw/rtl/waypoint_follower_offboard_sequencer.sv
// Top level of the waypoint follower: APB registers, controller and datapath.
//
// Items other than a tick (position, status, waypoint load, clear path) are
// taken in the idle state and give no result. A tick gives one setpoint
// transfer: for each waypoint checked against the acceptance radius it does
// one memory read and two squarings through the single shared 25x25
// multiplier, then up to 24 normalization shifts ahead of the CORDIC, and the
// CORDIC runs one micro-rotation a cycle, CORDIC_STEPS of them in all.
// When the target is within 0.2 m or no position is known the CORDIC is
// skipped and the held heading is sent. The result sits in an output register,
// so the next item is taken while the setpoint waits for its transfer; a new
// tick only stalls at its end if the previous setpoint is still pending.
// Registers are written over APB at byte address 4*index; pready is always high.
module waypoint_follower_offboard_sequencer #(
    parameter int MAX_WAYPOINTS = wfos_pkg::MAX_WAYPOINTS_DEF,
    parameter int CORDIC_STEPS  = wfos_pkg::CORDIC_STEPS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    wfos_in_if.sink                       i_in,
    wfos_out_if.source                    o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wfos_pkg::APB_AW-1:0]   paddr,
    input  logic [wfos_pkg::APB_DW-1:0]   pwdata,
    output logic [wfos_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    wfos_pkg::t_cfg       r_cfg;
    wfos_pkg::t_dp_status status;
    wfos_pkg::t_dp_op     dp_op;
    wfos_pkg::t_reg_idx   reg_idx;
    logic                 cfg_wr;
    logic                 in_ready;

    assign reg_idx = wfos_pkg::t_reg_idx'(paddr[wfos_pkg::APB_AW-1:2]);
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    // config writes land in the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cruise_altitude <= 24'sd3072;
            r_cfg.accept_radius   <= 23'd384;
            r_cfg.warmup_ticks    <= 17'd20;
            r_cfg.resend_ticks    <= 16'd20;
            r_cfg.hold_x          <= '0;
            r_cfg.hold_y          <= '0;
            r_cfg.auto_offboard   <= 1'b1;
            r_cfg.auto_arm        <= 1'b1;
        end else if (cfg_wr) begin
            case (reg_idx)
                wfos_pkg::REG_ALT:      r_cfg.cruise_altitude <= pwdata[wfos_pkg::ALT_W-1:0];
                wfos_pkg::REG_RADIUS:   r_cfg.accept_radius   <= pwdata[wfos_pkg::RAD_W-1:0];
                wfos_pkg::REG_WARMUP:   r_cfg.warmup_ticks    <= pwdata[wfos_pkg::WARM_W-1:0];
                wfos_pkg::REG_RESEND:   r_cfg.resend_ticks    <= pwdata[wfos_pkg::TICK_W-1:0];
                wfos_pkg::REG_HOLD_X:   r_cfg.hold_x          <= pwdata[wfos_pkg::POS_W-1:0];
                wfos_pkg::REG_HOLD_Y:   r_cfg.hold_y          <= pwdata[wfos_pkg::POS_W-1:0];
                wfos_pkg::REG_AUTO_OFB: r_cfg.auto_offboard   <= pwdata[0];
                wfos_pkg::REG_AUTO_ARM: r_cfg.auto_arm        <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            wfos_pkg::REG_ALT:      prdata = 32'(r_cfg.cruise_altitude);
            wfos_pkg::REG_RADIUS:   prdata = 32'(r_cfg.accept_radius);
            wfos_pkg::REG_WARMUP:   prdata = 32'(r_cfg.warmup_ticks);
            wfos_pkg::REG_RESEND:   prdata = 32'(r_cfg.resend_ticks);
            wfos_pkg::REG_HOLD_X:   prdata = 32'(r_cfg.hold_x);
            wfos_pkg::REG_HOLD_Y:   prdata = 32'(r_cfg.hold_y);
            wfos_pkg::REG_AUTO_OFB: prdata = 32'(r_cfg.auto_offboard);
            wfos_pkg::REG_AUTO_ARM: prdata = 32'(r_cfg.auto_arm);
            default:                prdata = '0;
        endcase
    end

    wfos_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_opcode   (i_in.opcode),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_dp_op    (dp_op)
    );

    assign i_in.ready = in_ready;

    wfos_dp #(
        .MAX_WAYPOINTS (MAX_WAYPOINTS),
        .CORDIC_STEPS  (CORDIC_STEPS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_dp_op         (dp_op),
        .i_cfg           (r_cfg),
        .i_opcode        (i_in.opcode),
        .i_in_x          (i_in.in_x),
        .i_in_y          (i_in.in_y),
        .i_in_heading    (i_in.in_heading),
        .i_xy_ok         (i_in.xy_ok),
        .i_heading_ok    (i_in.heading_ok),
        .i_armed_flag    (i_in.armed_flag),
        .i_offboard_flag (i_in.offboard_flag),
        .i_last_point    (i_in.last_point),
        .o_status        (status),
        .i_out_ready     (o_out.ready),
        .o_out_valid     (o_out.valid),
        .o_setpoint_x    (o_out.setpoint_x),
        .o_setpoint_y    (o_out.setpoint_y),
        .o_setpoint_z    (o_out.setpoint_z),
        .o_setpoint_yaw  (o_out.setpoint_yaw),
        .o_command_code  (o_out.command_code)
    );

endmodule

>>> hw/rtl/wfos_checker.sv
// Port-level assertions for the waypoint follower, bound to the top level.
module wfos_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               i_in_ready,
    input logic [wfos_pkg::OP_W-1:0]          i_in_opcode,
    input logic                               i_out_valid,
    input logic                               i_out_ready,
    input logic signed [wfos_pkg::ALT_W-1:0]  i_out_z,
    input logic [wfos_pkg::CODE_W-1:0]        i_out_code
);

    // a pending setpoint is not withdrawn
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("setpoint dropped before transfer");

    // a tick keeps the block busy for at least the following cycle
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_opcode == wfos_pkg::OP_TICK) |=> !i_in_ready)
        else $error("input taken right after a tick");

    a_code_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_code == wfos_pkg::CMD_NONE ||
                         i_out_code == wfos_pkg::CMD_OFFBOARD ||
                         i_out_code == wfos_pkg::CMD_ARM))
        else $error("illegal command code");

    a_z_nonpos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_z[wfos_pkg::ALT_W-1] || i_out_z == '0))
        else $error("setpoint z above ground reference");

endmodule

bind waypoint_follower_offboard_sequencer wfos_checker u_wfos_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_opcode (i_in.opcode),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_z     (o_out.setpoint_z),
    .i_out_code  (o_out.command_code)
);
